@@ src/rntf_pkg.sv @@
// ----------------------------------------------------------------------------
// rntf_pkg: shared types and constants for the rational note to frequency block
// Field widths, configuration register codes and pipeline constants.
// ----------------------------------------------------------------------------
package rntf_pkg;

  localparam int A4_W                = 26;
  localparam int TONIC_W             = 4;
  localparam int NOTE_W              = 7;
  localparam int FREQ_W              = 40;
  localparam int SLOT_W              = 16;
  localparam int CFG_DATA_W          = 64;
  localparam int CFG_IDX_W           = 3;
  localparam int PAIR_COUNT          = 6;
  localparam int PAIR_IDX_W          = 3;
  localparam int SHIFT_W             = 3;
  localparam int MAX_UP_SHIFT        = 5;
  localparam int MAX_DOWN_SHIFT      = 6;
  localparam int RATIO_BITS_DEFAULT  = 16;
  localparam int FRACTION_BITS       = 16;
  localparam int OCT_RECIP_W         = 8;
  localparam int OCT_RECIP_SHIFT     = 11;

  // input edge, three arithmetic stages, divider setup, one stage per
  // quotient bit, output register, then the edge that takes the result
  localparam int PIPE_LATENCY        = FREQ_W + 6;

  localparam logic [TONIC_W-1:0] PITCH_A    = 4'd9;
  localparam logic [TONIC_W-1:0] OCTAVE_LEN = 4'd12;
  localparam logic [TONIC_W-1:0] OCT_BIAS   = 4'd6;
  localparam logic [OCT_RECIP_W-1:0] OCT_RECIP = 8'd171;

  localparam logic [63:0] A4_RAW = 64'd440 << FRACTION_BITS;
  localparam logic [63:0] A4_MAX = (64'd1 << A4_W) - 64'd1;
  localparam logic [A4_W-1:0] A4_RESET = (A4_RAW > A4_MAX) ? A4_MAX[A4_W-1:0]
                                                           : A4_RAW[A4_W-1:0];

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A4_FREQUENCY = 3'd0,
    CFG_TONIC        = 3'd1,
    CFG_RATIO_PAIR_0 = 3'd2,
    CFG_RATIO_PAIR_1 = 3'd3,
    CFG_RATIO_PAIR_2 = 3'd4,
    CFG_RATIO_PAIR_3 = 3'd5,
    CFG_RATIO_PAIR_4 = 3'd6,
    CFG_RATIO_PAIR_5 = 3'd7
  } cfg_reg_e;

endpackage

@@ src/rational_note_to_frequency.sv @@
// ----------------------------------------------------------------------------
// rational_note_to_frequency: just intonation MIDI note to frequency
// Throughput: one item per cycle through every stage, including the 40 quotient bit stages.
// busy_o is high during reset and until the first clock edge after it; no stalls.
// Reset restores 440 Hz, tonic C and all ratios 1/1, and drops items in flight.
// ----------------------------------------------------------------------------
module rational_note_to_frequency #(
  parameter int RATIO_BITS = rntf_pkg::RATIO_BITS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [rntf_pkg::NOTE_W-1:0]         note_number_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rntf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rntf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                done_o,
  output logic [rntf_pkg::FREQ_W-1:0]         pitch_frequency_o,
  output logic                                ratio_error_o,
  output logic                                overflowed_o
);

  localparam int PROD_W  = 2 * RATIO_BITS;
  localparam int P1_W    = rntf_pkg::A4_W + RATIO_BITS;
  localparam int P3_W    = rntf_pkg::A4_W + PROD_W;
  localparam int NUM_W   = P3_W + rntf_pkg::MAX_UP_SHIFT;
  localparam int DEN_W   = PROD_W + rntf_pkg::MAX_DOWN_SHIFT;
  localparam int HI_W    = NUM_W - rntf_pkg::FREQ_W;
  localparam int STEPS   = rntf_pkg::FREQ_W;
  localparam int PAIR_W  = 4 * RATIO_BITS;
  localparam int FW      = rntf_pkg::FREQ_W;

  // configuration
  logic                         busy_q;
  logic [rntf_pkg::A4_W-1:0]    a4_q;
  logic [rntf_pkg::TONIC_W-1:0] tonic_q;
  logic [PAIR_W-1:0]            pair_q [rntf_pkg::PAIR_COUNT];
  logic [rntf_pkg::CFG_IDX_W-1:0] pair_sel;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = busy_q;
  assign pair_sel    = cfg_index_i - rntf_pkg::CFG_IDX_W'(rntf_pkg::CFG_RATIO_PAIR_0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a4_q    <= rntf_pkg::A4_RESET;
      tonic_q <= '0;
      for (int i = 0; i < rntf_pkg::PAIR_COUNT; i++) begin
        pair_q[i] <= {4{RATIO_BITS'(1)}};
      end
    end else if (cfg_valid_i) begin
      unique case (rntf_pkg::cfg_reg_e'(cfg_index_i))
        rntf_pkg::CFG_A4_FREQUENCY: begin
          a4_q <= cfg_data_i[rntf_pkg::A4_W-1:0];
        end
        rntf_pkg::CFG_TONIC: begin
          tonic_q <= cfg_data_i[rntf_pkg::TONIC_W-1:0];
        end
        rntf_pkg::CFG_RATIO_PAIR_0, rntf_pkg::CFG_RATIO_PAIR_1,
        rntf_pkg::CFG_RATIO_PAIR_2, rntf_pkg::CFG_RATIO_PAIR_3,
        rntf_pkg::CFG_RATIO_PAIR_4, rntf_pkg::CFG_RATIO_PAIR_5: begin
          pair_q[pair_sel] <= {cfg_data_i[3*rntf_pkg::SLOT_W +: RATIO_BITS],
                               cfg_data_i[2*rntf_pkg::SLOT_W +: RATIO_BITS],
                               cfg_data_i[rntf_pkg::SLOT_W +: RATIO_BITS],
                               cfg_data_i[0 +: RATIO_BITS]};
        end
        default: begin
        end
      endcase
    end
  end

  // tonic ratio lookup, follows the configuration
  logic [rntf_pkg::TONIC_W-1:0] tmod;
  logic                         tinv;
  logic [rntf_pkg::TONIC_W-1:0] tdist;
  logic [PAIR_W-1:0]            tpair_q;
  logic                         todd_q;
  logic                         tinv_q;

  assign tmod  = (tonic_q >= rntf_pkg::OCTAVE_LEN) ? tonic_q - rntf_pkg::OCTAVE_LEN : tonic_q;
  assign tinv  = tmod < rntf_pkg::PITCH_A;
  assign tdist = tinv ? rntf_pkg::PITCH_A - tmod : tmod - rntf_pkg::PITCH_A;

  always_ff @(posedge clk_i) begin
    tpair_q <= pair_q[tdist[rntf_pkg::TONIC_W-1:1]];
    todd_q  <= tdist[0];
    tinv_q  <= tinv;
  end

  // stage 0: input register
  logic                        v0_q;
  logic [rntf_pkg::NOTE_W-1:0] note_q;

  // stage 1: octave, pitch class, interval, note ratio read
  logic [rntf_pkg::NOTE_W+rntf_pkg::OCT_RECIP_W-1:0] oct_prod;
  logic [3:0]                  oct;
  logic [rntf_pkg::NOTE_W-1:0] oct_x12;
  logic [rntf_pkg::NOTE_W-1:0] pc;
  logic [3:0]                  pc4;
  logic                        borrow;
  logic [3:0]                  idx;
  logic [3:0]                  oct_sum;
  logic [rntf_pkg::SHIFT_W-1:0] sl_d;
  logic [rntf_pkg::SHIFT_W-1:0] sr_d;

  logic                         v1_q;
  logic [PAIR_W-1:0]            pair1_q;
  logic                         odd1_q;
  logic [rntf_pkg::SHIFT_W-1:0] sl1_q;
  logic [rntf_pkg::SHIFT_W-1:0] sr1_q;

  assign oct_prod = note_q * rntf_pkg::OCT_RECIP;
  assign oct      = oct_prod[rntf_pkg::OCT_RECIP_SHIFT +: 4];
  assign oct_x12  = {3'b000, oct} * rntf_pkg::NOTE_W'(rntf_pkg::OCTAVE_LEN);
  assign pc       = note_q - oct_x12;
  assign pc4      = pc[3:0];
  assign borrow   = pc4 < tmod;
  assign idx      = borrow ? pc4 + rntf_pkg::OCTAVE_LEN - tmod : pc4 - tmod;
  assign oct_sum  = oct + 4'd1 - {3'b000, borrow};
  assign sl_d     = (oct_sum >= rntf_pkg::OCT_BIAS) ?
                    rntf_pkg::SHIFT_W'(oct_sum - rntf_pkg::OCT_BIAS) : '0;
  assign sr_d     = (oct_sum < rntf_pkg::OCT_BIAS) ?
                    rntf_pkg::SHIFT_W'(rntf_pkg::OCT_BIAS - oct_sum) : '0;

  // stage 2: ratio select, zero divisor check, first products
  logic [RATIO_BITS-1:0] tnum;
  logic [RATIO_BITS-1:0] tden;
  logic [RATIO_BITS-1:0] tn;
  logic [RATIO_BITS-1:0] td;
  logic [RATIO_BITS-1:0] rn;
  logic [RATIO_BITS-1:0] rd;

  logic                         v2_q;
  logic                         err2_q;
  logic [P1_W-1:0]              p1_q;
  logic [RATIO_BITS-1:0]        rn2_q;
  logic [PROD_W-1:0]            den2_q;
  logic [rntf_pkg::SHIFT_W-1:0] sl2_q;
  logic [rntf_pkg::SHIFT_W-1:0] sr2_q;

  assign tnum = todd_q ? tpair_q[2*RATIO_BITS +: RATIO_BITS] : tpair_q[0 +: RATIO_BITS];
  assign tden = todd_q ? tpair_q[3*RATIO_BITS +: RATIO_BITS] : tpair_q[RATIO_BITS +: RATIO_BITS];
  assign tn   = tinv_q ? tden : tnum;
  assign td   = tinv_q ? tnum : tden;
  assign rn   = odd1_q ? pair1_q[2*RATIO_BITS +: RATIO_BITS] : pair1_q[0 +: RATIO_BITS];
  assign rd   = odd1_q ? pair1_q[3*RATIO_BITS +: RATIO_BITS] : pair1_q[RATIO_BITS +: RATIO_BITS];

  // stage 3: full numerator and denominator with the octave shift
  logic [P3_W-1:0]  prod3;
  logic             v3_q;
  logic             err3_q;
  logic [NUM_W-1:0] num3_q;
  logic [DEN_W-1:0] den3_q;

  assign prod3 = p1_q * rn2_q;

  // divider, entry 0 is the setup stage
  logic [DEN_W-1:0] num_hi;
  logic             dv_q   [STEPS+1];
  logic             derr_q [STEPS+1];
  logic             dovf_q [STEPS+1];
  logic [DEN_W-1:0] drem_q [STEPS+1];
  logic [DEN_W-1:0] dden_q [STEPS+1];
  logic [FW-1:0]    dword_q[STEPS+1];
  logic [DEN_W:0]   trial  [STEPS];
  logic             ge     [STEPS];

  assign num_hi = {{(DEN_W-HI_W){1'b0}}, num3_q[NUM_W-1:FW]};

  always_comb begin
    for (int j = 0; j < STEPS; j++) begin
      trial[j] = {drem_q[j], dword_q[j][FW-1]};
      ge[j]    = trial[j] >= {1'b0, dden_q[j]};
    end
  end

  // output register
  logic          done_q;
  logic [FW-1:0] pitch_q;
  logic          rerr_q;
  logic          rovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
      for (int j = 0; j <= STEPS; j++) begin
        dv_q[j] <= 1'b0;
      end
    end else begin
      v0_q    <= start_i && !busy_q;
      v1_q    <= v0_q;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      dv_q[0] <= v3_q;
      for (int j = 0; j < STEPS; j++) begin
        dv_q[j+1] <= dv_q[j];
      end
      done_q  <= dv_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    note_q     <= note_number_i;

    pair1_q    <= pair_q[idx[3:1]];
    odd1_q     <= idx[0];
    sl1_q      <= sl_d;
    sr1_q      <= sr_d;

    err2_q     <= (td == '0) || (rd == '0);
    p1_q       <= a4_q * tn;
    rn2_q      <= rn;
    den2_q     <= td * rd;
    sl2_q      <= sl1_q;
    sr2_q      <= sr1_q;

    err3_q     <= err2_q;
    num3_q     <= {{rntf_pkg::MAX_UP_SHIFT{1'b0}}, prod3} << sl2_q;
    den3_q     <= {{rntf_pkg::MAX_DOWN_SHIFT{1'b0}}, den2_q} << sr2_q;

    derr_q[0]  <= err3_q;
    dovf_q[0]  <= num_hi >= den3_q;
    drem_q[0]  <= num_hi;
    dden_q[0]  <= den3_q;
    dword_q[0] <= num3_q[FW-1:0];

    for (int j = 0; j < STEPS; j++) begin
      derr_q[j+1]  <= derr_q[j];
      dovf_q[j+1]  <= dovf_q[j];
      dden_q[j+1]  <= dden_q[j];
      drem_q[j+1]  <= ge[j] ? DEN_W'(trial[j] - {1'b0, dden_q[j]}) : trial[j][DEN_W-1:0];
      dword_q[j+1] <= {dword_q[j][FW-2:0], ge[j]};
    end

    rerr_q  <= derr_q[STEPS];
    rovf_q  <= !derr_q[STEPS] && dovf_q[STEPS];
    if (derr_q[STEPS]) begin
      pitch_q <= '0;
    end else if (dovf_q[STEPS]) begin
      pitch_q <= '1;
    end else begin
      pitch_q <= dword_q[STEPS];
    end
  end

  assign done_o            = done_q;
  assign pitch_frequency_o = pitch_q;
  assign ratio_error_o     = rerr_q;
  assign overflowed_o      = rovf_q;

endmodule

@@ src/rntf_checker.sv @@
// ----------------------------------------------------------------------------
// rntf_checker: port level checks for rational_note_to_frequency
// Fixed latency between accepted items and result strobes, and flag rules.
// ----------------------------------------------------------------------------
module rntf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o,
  input logic [rntf_pkg::FREQ_W-1:0]   pitch_frequency_o,
  input logic                          ratio_error_o,
  input logic                          overflowed_o
);

  // every accepted item gives its strobe after the fixed latency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(rntf_pkg::PIPE_LATENCY) done_o)
    else $error("item accepted without a result at the fixed latency");

  // no strobe without an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, rntf_pkg::PIPE_LATENCY))
    else $error("result strobe without a matching item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ratio_error_o |-> pitch_frequency_o == '0 && !overflowed_o)
    else $error("ratio error with nonzero frequency or overflow flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && overflowed_o |-> pitch_frequency_o == '1)
    else $error("overflow flag without saturated frequency");

endmodule

bind rational_note_to_frequency rntf_checker u_rntf_checker (.*);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for rational_note_to_frequency
// Sends MIDI notes through the command port and predicts each pitch from a
// local copy of the tuning registers. Every result strobe is compared field
// by field with the oldest pending prediction. Directed tests cover the reset
// tuning, saturation, zero divisors, tonic wrap and a zero reference; random
// phases follow with varied tunings and sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int NOTES_PER_PHASE = 70;
  localparam int PHASE_COUNT = 12;
  localparam logic [63:0] FREQ_LIMIT = (64'd1 << rntf_pkg::FREQ_W) - 64'd1;

  typedef struct packed {
    logic [rntf_pkg::FREQ_W-1:0] freq;
    logic                        err;
    logic                        ovf;
  } pitch_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  logic [rntf_pkg::NOTE_W-1:0]     note_number;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [rntf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rntf_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            done;
  logic [rntf_pkg::FREQ_W-1:0]     pitch_frequency;
  logic                            ratio_error;
  logic                            overflowed;

  logic [rntf_pkg::A4_W-1:0]       cur_a4;
  logic [rntf_pkg::TONIC_W-1:0]    cur_tonic;
  logic [63:0]                     cur_pairs [rntf_pkg::PAIR_COUNT];

  pitch_result_t         expected_pitches [$];
  pitch_result_t         due;
  int                    mismatches = 0;
  int                    cycles = 0;
  int                    idle_pct = 0;

  rational_note_to_frequency u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start_i           (start),
    .busy_o            (busy),
    .note_number_i     (note_number),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .done_o            (done),
    .pitch_frequency_o (pitch_frequency),
    .ratio_error_o     (ratio_error),
    .overflowed_o      (overflowed)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic pitch_result_t pitch_of_note(logic [rntf_pkg::NOTE_W-1:0] note);
    pitch_result_t r;
    int octave;
    int pc;
    int t;
    int idx;
    int a_offset;
    int k;
    int shift;
    logic [15:0] tn;
    logic [15:0] td;
    logic [15:0] rn;
    logic [15:0] rd;
    logic [15:0] swap;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    octave = int'(note) / 12 - 1;
    pc = int'(note) % 12;
    t = int'(cur_tonic);
    if (t >= 12) t -= 12;
    idx = pc - t;
    if (idx < 0) begin
      octave--;
      idx += 12;
    end
    a_offset = t - int'(rntf_pkg::PITCH_A);
    k = (a_offset < 0) ? -a_offset : a_offset;
    tn = cur_pairs[k >> 1][(k & 1) * 32 +: 16];
    td = cur_pairs[k >> 1][(k & 1) * 32 + 16 +: 16];
    if (a_offset < 0) begin
      swap = tn;
      tn = td;
      td = swap;
    end
    rn = cur_pairs[idx >> 1][(idx & 1) * 32 +: 16];
    rd = cur_pairs[idx >> 1][(idx & 1) * 32 + 16 +: 16];
    r = '0;
    if (td == 16'd0 || rd == 16'd0) begin
      r.err = 1'b1;
    end else begin
      num = 64'(cur_a4) * 64'(tn) * 64'(rn);
      den = 64'(td) * 64'(rd);
      shift = octave - 4;
      if (shift >= 0) num = num << shift;
      else den = den << (-shift);
      quo = num / den;
      if (quo > FREQ_LIMIT) begin
        r.freq = '1;
        r.ovf = 1'b1;
      end else begin
        r.freq = quo[rntf_pkg::FREQ_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && done) begin
      if (expected_pitches.size() == 0) begin
        report_mismatch("result strobe with no item pending");
      end else begin
        due = expected_pitches.pop_front();
        if (pitch_frequency !== due.freq)
          report_mismatch($sformatf("pitch_frequency %0d, want %0d", pitch_frequency, due.freq));
        if (ratio_error !== due.err)
          report_mismatch($sformatf("ratio_error %0b, want %0b", ratio_error, due.err));
        if (overflowed !== due.ovf)
          report_mismatch($sformatf("overflowed %0b, want %0b", overflowed, due.ovf));
      end
    end
  end

  task automatic send_note(logic [rntf_pkg::NOTE_W-1:0] n);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    note_number <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_pitches.push_back(pitch_of_note(n));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_pitches.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(rntf_pkg::cfg_reg_e idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rntf_pkg::CFG_A4_FREQUENCY: cur_a4 = data[rntf_pkg::A4_W-1:0];
      rntf_pkg::CFG_TONIC:        cur_tonic = data[rntf_pkg::TONIC_W-1:0];
      default: cur_pairs[int'(idx) - int'(rntf_pkg::CFG_RATIO_PAIR_0)] = data;
    endcase
  endtask

  task automatic write_all_pairs(logic [63:0] data);
    for (int i = 0; i < rntf_pkg::PAIR_COUNT; i++)
      write_reg(rntf_pkg::cfg_reg_e'(int'(rntf_pkg::CFG_RATIO_PAIR_0) + i), data);
  endtask

  task automatic end_cfg();
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_slot();
    case ($urandom_range(15))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_reset_tuning();
    send_note(7'd0);
    send_note(7'd127);
    send_note(7'd60);
    send_note(7'd69);
    wait_idle();
  endtask

  task automatic test_saturation();
    write_reg(rntf_pkg::CFG_A4_FREQUENCY, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(rntf_pkg::CFG_TONIC, 64'd9);
    write_all_pairs(64'h0001_FFFF_0001_FFFF);
    end_cfg();
    send_note(7'd127);
    send_note(7'd0);
    send_note(7'd69);
    wait_idle();
  endtask

  task automatic test_zero_divisor();
    write_reg(rntf_pkg::CFG_A4_FREQUENCY, 64'(rntf_pkg::A4_RESET));
    write_all_pairs(64'h0003_0005_0002_0003);
    // inverted tonic ratio with zero numerator
    write_reg(rntf_pkg::CFG_RATIO_PAIR_3, 64'h0001_0000_0002_0003);
    write_reg(rntf_pkg::CFG_TONIC, 64'd2);
    end_cfg();
    send_note(7'd62);
    wait_idle();
    // note ratio with zero denominator
    write_reg(rntf_pkg::CFG_RATIO_PAIR_1, 64'h0000_0005_0002_0003);
    write_reg(rntf_pkg::CFG_TONIC, 64'd9);
    end_cfg();
    send_note(7'd72);
    send_note(7'd69);
    wait_idle();
    // zero numerator that is not inverted
    write_reg(rntf_pkg::CFG_RATIO_PAIR_1, 64'h0000_0005_0002_0000);
    write_reg(rntf_pkg::CFG_TONIC, 64'd11);
    end_cfg();
    send_note(7'd71);
    send_note(7'd74);
    wait_idle();
    // tonic ratio with zero denominator
    write_reg(rntf_pkg::CFG_RATIO_PAIR_0, 64'h0000_0005_0002_0003);
    write_reg(rntf_pkg::CFG_TONIC, 64'd10);
    end_cfg();
    send_note(7'd70);
    wait_idle();
  endtask

  task automatic test_tonic_wrap();
    for (int i = 0; i < rntf_pkg::PAIR_COUNT; i++)
      write_reg(rntf_pkg::cfg_reg_e'(int'(rntf_pkg::CFG_RATIO_PAIR_0) + i),
                {16'(2 * i + 5), 16'(2 * i + 7), 16'(2 * i + 3), 16'(2 * i + 4)});
    write_reg(rntf_pkg::CFG_TONIC, 64'd12);
    end_cfg();
    send_note(7'd60);
    send_note(7'd61);
    wait_idle();
    write_reg(rntf_pkg::CFG_TONIC, 64'd15);
    end_cfg();
    send_note(7'd59);
    send_note(7'd65);
    wait_idle();
  endtask

  task automatic test_zero_reference();
    write_reg(rntf_pkg::CFG_A4_FREQUENCY, 64'hFFFF_FFFF_FC00_0000);
    end_cfg();
    send_note(7'd69);
    send_note(7'd127);
    wait_idle();
  endtask

  task automatic random_tuning(int phase);
    logic [63:0] a4_word;
    case (phase)
      0: begin
        write_reg(rntf_pkg::CFG_A4_FREQUENCY, 64'(rntf_pkg::A4_MAX));
        write_reg(rntf_pkg::CFG_TONIC, 64'($urandom_range(15)));
        write_all_pairs(64'h0001_FFFF_0001_FFFF);
      end
      1: begin
        write_reg(rntf_pkg::CFG_A4_FREQUENCY, 64'd1);
        write_reg(rntf_pkg::CFG_TONIC, 64'($urandom_range(15)));
        write_all_pairs(64'hFFFF_0001_FFFF_0001);
      end
      default: begin
        case ($urandom_range(3))
          0:       a4_word = 64'(rntf_pkg::A4_MAX);
          1:       a4_word = 64'($urandom_range(1, 1000));
          2:       a4_word = {$urandom, $urandom};
          default: a4_word = 64'($urandom_range(1, 2 ** rntf_pkg::A4_W - 1));
        endcase
        write_reg(rntf_pkg::CFG_A4_FREQUENCY, a4_word);
        if ($urandom_range(3) != 0) write_reg(rntf_pkg::CFG_TONIC, {$urandom, $urandom});
        for (int i = 0; i < rntf_pkg::PAIR_COUNT; i++)
          if ($urandom_range(3) != 0)
            write_reg(rntf_pkg::cfg_reg_e'(int'(rntf_pkg::CFG_RATIO_PAIR_0) + i),
                      {rand_slot(), rand_slot(), rand_slot(), rand_slot()});
      end
    endcase
    end_cfg();
  endtask

  task automatic test_random_traffic();
    int pcts [3];
    pcts = '{0, 74, 31};
    for (int p = 0; p < PHASE_COUNT; p++) begin
      random_tuning(p);
      idle_pct = pcts[p % 3];
      repeat (NOTES_PER_PHASE) send_note(rntf_pkg::NOTE_W'($urandom_range(127)));
      wait_idle();
    end
    idle_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    note_number = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_a4 = rntf_pkg::A4_RESET;
    cur_tonic = '0;
    for (int i = 0; i < rntf_pkg::PAIR_COUNT; i++) cur_pairs[i] = 64'h0001_0001_0001_0001;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_tuning();
    test_saturation();
    test_zero_divisor();
    test_tonic_wrap();
    test_zero_reference();
    test_random_traffic();

    wait_idle();
    repeat (rntf_pkg::PIPE_LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && expected_pitches.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
